@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the ordered list RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted (active low)
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// clocked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ rtl/olp_pkg.sv @@
// ----------------------------------------------------------------------------
// olp_pkg
// Shared types and codes for the ordered list block.
// ----------------------------------------------------------------------------
package olp_pkg;

  localparam int VAL_W       = 32;
  localparam int OUT_CNT_W   = 5;
  localparam int MAX_RESULTS = 16;

  // operation codes on in_tuser
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // result status codes on out_tuser
  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ELEMENT   = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_READ
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;    // take neighbor toward the front (insert at front)
    logic shift;   // compaction step: close the first hole
    logic rotate;  // take neighbor toward the back; the back cell takes the front
    logic mark;    // flag entries equal to the key
  } cell_ctrl_t;

endpackage

@@ rtl/olp_cell.sv @@
// ----------------------------------------------------------------------------
// olp_cell
// One list slot: holds a value and a delete flag, moves data to neighbors.
// ----------------------------------------------------------------------------
module olp_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  olp_pkg::cell_ctrl_t        ctrl,
  input  logic [olp_pkg::VAL_W-1:0]  key,
  input  logic                       in_range,
  input  logic [olp_pkg::VAL_W-1:0]  prev_val,
  input  logic [olp_pkg::VAL_W-1:0]  next_val,
  input  logic                       next_dead,
  input  logic                       hole_in,
  output logic                       hole_out,
  output logic [olp_pkg::VAL_W-1:0]  val,
  output logic                       dead
);

  logic [olp_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      dead_r, dead_nxt;

  // a hole at or ahead of this slot means this slot pulls from behind
  assign hole_out = hole_in | dead_r;

  always_comb begin
    val_nxt  = val_r;
    dead_nxt = dead_r;
    if (ctrl.push) begin
      val_nxt = prev_val;
    end else if (ctrl.rotate) begin
      val_nxt = next_val;
    end else if (ctrl.shift && hole_out) begin
      val_nxt  = next_val;
      dead_nxt = next_dead;
    end else if (ctrl.mark) begin
      dead_nxt = in_range && (val_r == key);
    end
  end

  // value needs no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= 1'b0;
    end else begin
      dead_r <= dead_nxt;
    end
  end

  assign val  = val_r;
  assign dead = dead_r;

endmodule

@@ rtl/ordered_list_push_front_remove_value.sv @@
// Push, unused op, full push and read of an empty list: one result word, valid
//   the cycle after accept; a stalled output holds off the next input word.
// Remove: flags matches on accept, then closes the deleted entries one at a time
//   through the cell chain, then gives the result word once the output is free.
// Read: one element per cycle from the front cell, when the output is not stalled,
//   while the chain rotates a full turn home. Reset empties the list.
// ----------------------------------------------------------------------------
// ordered_list_push_front_remove_value
// Ordered list of signed values in a chain of cells: push front, remove all
// equal entries with gap closing, and read-out front to back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_push_front_remove_value #(
  parameter int LIST_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] element, [36:32] removed_count,
                                  // [41:37] length, [47:42] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int RD_LIM = (LIST_DEPTH < olp_pkg::MAX_RESULTS) ?
                          LIST_DEPTH : olp_pkg::MAX_RESULTS;
  localparam int VW     = olp_pkg::VAL_W;
  localparam int OW     = olp_pkg::OUT_CNT_W;

  // control registers
  olp_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   rd_r, rd_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  olp_pkg::status_t   out_status_r, out_status_nxt;
  logic [VW-1:0]      out_elem_r, out_elem_nxt;
  logic [OW-1:0]      out_rem_r, out_rem_nxt;
  logic [OW-1:0]      out_len_r, out_len_nxt;
  logic               out_last_r, out_last_nxt;

  // cell chain
  olp_pkg::cell_ctrl_t   ctrl;
  logic [VW-1:0]         cell_val  [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_dead;
  logic [LIST_DEPTH-1:0] in_rng;
  logic [LIST_DEPTH:0]   hole;

  logic             in_acc;
  logic             out_free;
  logic             full;
  logic             any_dead;
  logic [CNT_W-1:0] rd_lim;
  olp_pkg::op_t     op;

  // terms for the checks
  logic             rem_shift;
  logic             push_ok;
  logic             in_read;
  logic             rd_ok;

  assign op       = olp_pkg::op_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == olp_pkg::S_IDLE) && out_free;
  assign in_acc   = in_tvalid && in_tready;
  assign full     = (count_r == CNT_W'(LIST_DEPTH));
  assign any_dead = hole[LIST_DEPTH];
  assign rd_lim   = (count_r > CNT_W'(RD_LIM)) ? CNT_W'(RD_LIM) : count_r;
  assign hole[0]  = 1'b0;

  // cells, front at index 0
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [VW-1:0] prev_v, next_v;
    logic          next_d;

    assign in_rng[g] = (count_r > CNT_W'(g));

    if (g == 0) begin : g_front
      assign prev_v = in_tdata;
    end else begin : g_mid
      assign prev_v = cell_val[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_back
      assign next_v = cell_val[0];
      assign next_d = 1'b0;
    end else begin : g_inner
      assign next_v = cell_val[g+1];
      assign next_d = cell_dead[g+1];
    end

    olp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .key       (in_tdata),
      .in_range  (in_rng[g]),
      .prev_val  (prev_v),
      .next_val  (next_v),
      .next_dead (next_d),
      .hole_in   (hole[g]),
      .hole_out  (hole[g+1]),
      .val       (cell_val[g]),
      .dead      (cell_dead[g])
    );
  end

  // sequencer: next state, cell commands and result word
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    rd_nxt         = rd_r;
    ctrl           = '0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_rem_nxt    = out_rem_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      olp_pkg::S_IDLE: begin
        if (in_acc) begin
          out_elem_nxt = '0;
          out_rem_nxt  = '0;
          out_last_nxt = 1'b1;
          case (op)
            olp_pkg::OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = olp_pkg::ST_FULL;
                out_len_nxt    = OW'(count_r);
              end else begin
                ctrl.push      = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = olp_pkg::ST_DONE;
                out_len_nxt    = OW'(count_r + 1'b1);
              end
            end
            olp_pkg::OP_REMOVE: begin
              ctrl.mark = 1'b1;
              rem_nxt   = '0;
              state_nxt = olp_pkg::S_REM;
            end
            olp_pkg::OP_READ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = olp_pkg::ST_EMPTY;
                out_len_nxt    = '0;
              end else begin
                rd_nxt    = '0;
                state_nxt = olp_pkg::S_READ;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = olp_pkg::ST_DONE;
              out_len_nxt    = OW'(count_r);
            end
          endcase
        end
      end

      // close one hole per cycle, then report
      olp_pkg::S_REM: begin
        if (any_dead) begin
          ctrl.shift = 1'b1;
          count_nxt  = count_r - 1'b1;
          rem_nxt    = rem_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (rem_r != '0) ? olp_pkg::ST_DONE : olp_pkg::ST_NOT_FOUND;
          out_elem_nxt   = '0;
          out_rem_nxt    = OW'(rem_r);
          out_len_nxt    = OW'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = olp_pkg::S_IDLE;
        end
      end

      // emit front cell and rotate; finish a full turn to restore order
      olp_pkg::S_READ: begin
        if (rd_r < rd_lim) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = olp_pkg::ST_ELEMENT;
            out_elem_nxt   = cell_val[0];
            out_rem_nxt    = '0;
            out_len_nxt    = OW'(count_r);
            out_last_nxt   = ((rd_r + 1'b1) == rd_lim);
            ctrl.rotate    = 1'b1;
            rd_nxt         = rd_r + 1'b1;
          end
        end else if (rd_r < CNT_W'(LIST_DEPTH)) begin
          ctrl.rotate = 1'b1;
          rd_nxt      = rd_r + 1'b1;
        end else begin
          state_nxt = olp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = olp_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olp_pkg::S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_rem_r    <= out_rem_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_len_r, out_rem_r, out_elem_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // checks
  assign rem_shift = (state_r == olp_pkg::S_REM) && any_dead;
  assign push_ok   = in_acc && (op == olp_pkg::OP_PUSH) && !full;
  assign in_read   = (state_r == olp_pkg::S_READ);
  assign rd_ok     = (rd_r <= CNT_W'(LIST_DEPTH));

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CNT_W'(LIST_DEPTH), "count above depth")
  `ASSERT_CLK(a_rem_step, clk, rst_n, rem_shift |=> count_r == $past(count_r) - 1'b1, "bad shift")
  `ASSERT_CLK(a_push_grow, clk, rst_n, push_ok |=> count_r == $past(count_r) + 1'b1, "bad push")
  `ASSERT_CLK(a_read_quiet, clk, rst_n, in_read |-> !in_tready && rd_ok, "bad read")

endmodule

@@ bench/list_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_scoreboard_pkg
// Scoreboard for the ordered list: it keeps its own copy of the list, works
// out the result words each accepted input word causes, and checks the
// result words in order as they leave the block.
// ----------------------------------------------------------------------------
package list_scoreboard_pkg;

  import olp_pkg::*;

  // one result word, split into its fields
  typedef struct packed {
    status_t     status;
    logic [31:0] element;
    logic [4:0]  removed;
    logic [4:0]  length;
    logic        last;
  } list_result_t;

  class list_scoreboard;

    int unsigned  depth;
    logic [31:0]  held[$];     // list contents, front first
    list_result_t pending_q[$];
    int           errors;

    function new(int unsigned list_depth);
      depth  = list_depth;
      errors = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void add_result(status_t st, logic [31:0] el, int unsigned rc,
                             int unsigned len, logic lst);
      list_result_t r;
      r.status  = st;
      r.element = el;
      r.removed = rc[4:0];
      r.length  = len[4:0];
      r.last    = lst;
      pending_q.push_back(r);
    endfunction

    // update the list for one accepted input word and queue its results
    function void note_word(op_t op, logic [31:0] value);
      logic [31:0] kept[$];
      int unsigned n;
      int unsigned removed;
      case (op)
        OP_PUSH: begin
          if (held.size() >= depth) begin
            add_result(ST_FULL, '0, 0, held.size(), 1'b1);
          end else begin
            held.push_front(value);
            add_result(ST_DONE, '0, 0, held.size(), 1'b1);
          end
        end
        OP_REMOVE: begin
          foreach (held[i]) if (held[i] != value) kept.push_back(held[i]);
          removed = held.size() - kept.size();
          held = kept;
          add_result((removed != 0) ? ST_DONE : ST_NOT_FOUND, '0, removed,
                     held.size(), 1'b1);
        end
        OP_READ: begin
          if (held.size() == 0) begin
            add_result(ST_EMPTY, '0, 0, 0, 1'b1);
          end else begin
            n = (held.size() < MAX_RESULTS) ? held.size() : MAX_RESULTS;
            for (int i = 0; i < n; i++)
              add_result(ST_ELEMENT, held[i], 0, held.size(), (i + 1 == n));
          end
        end
        default: begin
          add_result(ST_DONE, '0, 0, held.size(), 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one accepted result word against the oldest expectation
    task check_word(logic [47:0] data, logic [2:0] stat, logic lst);
      list_result_t w;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d data=%h last=%b",
                                  stat, data, lst));
        return;
      end
      w = pending_q.pop_front();
      if (stat !== w.status)
        report_mismatch($sformatf("status %0d, want %s", stat, w.status.name()));
      if (data[31:0] !== w.element)
        report_mismatch($sformatf("element %h, want %h", data[31:0], w.element));
      if (data[36:32] !== w.removed)
        report_mismatch($sformatf("removed_count %0d, want %0d", data[36:32],
                                  w.removed));
      if (data[41:37] !== w.length)
        report_mismatch($sformatf("length %0d, want %0d", data[41:37], w.length));
      if (data[47:42] !== 6'd0)
        report_mismatch($sformatf("pad bits %b, want zero", data[47:42]));
      if (lst !== w.last)
        report_mismatch($sformatf("last %b, want %b", lst, w.last));
    endtask

  endclass

endpackage

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the ordered list block: directed pushes, removes and reads
// over the corner cases, then random traffic with idling on both sides and
// a long output stall, all checked word by word by the scoreboard.
// ----------------------------------------------------------------------------
module tb;

  import olp_pkg::*;
  import list_scoreboard_pkg::*;

  localparam int DEPTH = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [31:0] element, [36:32] removed_count,
                                // [41:37] length, [47:42] zero
  logic [2:0]  out_tuser;       // [2:0] status
  logic        out_tlast;

  int tx_idle_pct = 34;
  int rx_idle_pct = 81;
  int hold_left = 0;

  list_scoreboard sb = new(DEPTH);

  ordered_list_push_front_remove_value #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // monitor both channels, input first so a same-cycle result finds its
  // expectation; then drive tready, with a counted hold-off when requested
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(op_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
    end
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(op_t op, logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // global timeout
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] fill_vals[16];
    logic [31:0] pool[8];
    int          push_pct;
    int          r;
    op_t         op;
    logic [31:0] value;

    // fill values include the sign extremes and four copies of 5
    fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'd5, 32'hAAAA_AAAA, 32'd5, 32'h5555_5555,
                  32'd5, 32'h0000_0001, 32'hFFFF_FFFE, 32'd5,
                  32'h1234_5678, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_F0F0};
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'd7, $urandom, $urandom, $urandom};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list cases, fill to full, overflow, remove, read-out
    send_word(OP_READ, 32'h0);
    send_word(OP_REMOVE, 32'd5);
    send_word(OP_NOP, 32'h0);
    foreach (fill_vals[i]) send_word(OP_PUSH, fill_vals[i]);
    send_word(OP_PUSH, 32'h0001_2345);
    send_word(OP_READ, 32'hFFFF_FFFF);
    send_word(OP_REMOVE, 32'd5);
    send_word(OP_REMOVE, 32'd19);
    send_word(OP_READ, 32'h0);
    send_word(OP_NOP, 32'hFFFF_FFFF);

    // random traffic in three idling phases; long output stall in the last
    for (int k = 0; k < 300; k++) begin
      if (k == 100) begin
        tx_idle_pct <= 81;
        rx_idle_pct <= 34;
      end
      if (k == 200) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_left   <= 400;
      end
      // alternate between filling and draining stretches
      push_pct = ((k / 25) % 2 == 0) ? 70 : 30;
      r = $urandom_range(99);
      if (r < push_pct) op = OP_PUSH;
      else if (r < push_pct + (100 - push_pct) * 6 / 10) op = OP_REMOVE;
      else if (r < 95) op = OP_READ;
      else op = OP_NOP;
      value = ($urandom_range(3) != 0) ? pool[$urandom_range(7)] : $urandom;
      send_word(op, value);
    end
    in_tvalid <= 1'b0;

    // drain, then allow for a full read-out pass before deciding
    while (sb.pending() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
